>>> src/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/kane_pkg.sv
// Package: widths, byte codes and state types of the amount number extractor.
`timescale 1ns / 1ps

package kane_pkg;

	localparam int VALUE_BITS = 63;
	localparam int UNIT_BITS  = 14;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [7:0] LEAD_EB = 8'hEB;
	localparam logic [7:0] LEAD_EC = 8'hEC;
	localparam logic [7:0] MID_A7  = 8'hA7;
	localparam logic [7:0] MID_B0  = 8'hB0;
	localparam logic [7:0] MID_B2  = 8'hB2;
	localparam logic [7:0] MID_8B  = 8'h8B;
	localparam logic [7:0] TAIL_8C = 8'h8C;
	localparam logic [7:0] TAIL_9C = 8'h9C;
	localparam logic [7:0] TAIL_B1 = 8'hB1;
	localparam logic [7:0] TAIL_AD = 8'hAD;

	localparam logic [UNIT_BITS-1:0] UNIT_10000 = UNIT_BITS'(10000);
	localparam logic [UNIT_BITS-1:0] UNIT_1000  = UNIT_BITS'(1000);
	localparam logic [UNIT_BITS-1:0] UNIT_100   = UNIT_BITS'(100);
	localparam logic [UNIT_BITS-1:0] UNIT_10    = UNIT_BITS'(10);
	localparam logic [UNIT_BITS-1:0] UNIT_NONE  = '0;

	localparam logic [1:0] PC_EMPTY = 2'd0;
	localparam logic [1:0] PC_ONE   = 2'd1;
	localparam logic [1:0] PC_TWO   = 2'd2;

	typedef struct packed {
		logic [VALUE_BITS-1:0] unit_total;
		logic [VALUE_BITS-1:0] last_number;
		logic                  have_number;
		logic                  in_unit_expression;
		logic                  total_overflowed;
	} kane_expr_t;

	typedef struct packed {
		kane_expr_t            expr;
		logic [VALUE_BITS-1:0] digit_run_value;
		logic                  in_digit_run;
		logic                  run_overflowed;
		logic [15:0]           prefix_bytes;
		logic [1:0]            prefix_count;
	} kane_state_t;

	typedef struct packed {
		logic                  number_found;
		logic [VALUE_BITS-1:0] number_value;
		logic                  text_done;
	} kane_result_t;

endpackage

>>> src/korean_amount_number_extractor.sv
// Top level: byte-stream number extractor with input and result registers.
// One text byte is taken per cycle while the output side does not stall, and each
// byte yields exactly one result, which passes the input register and then the
// result register. The rate is one byte per clock, set by the update of the stored
// expression state (digit run, pending unit prefix and unit total), which every byte
// reads and writes; the result register lets a new byte enter while a result waits.
// A stalled output holds the byte in the input register and then stalls input.
// Reset clears the valid flags and the expression state; end_of_text also clears that state after the closing flush.
`timescale 1ns / 1ps

module korean_amount_number_extractor import kane_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            text_byte,
	input  logic                  end_of_text,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  number_found,
	output logic [VALUE_BITS-1:0] number_value,
	output logic                  text_done
);

	logic         v_s1;
	logic [7:0]   byte_s1;
	logic         eot_s1;
	logic         v_s2;
	kane_result_t res_s2;
	kane_state_t  state_q;
	kane_state_t  state_nxt;
	kane_result_t res;
	logic         adv_s1;

	assign adv_s1   = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv_s1;

	kane_step u_step (
		.state_cur   (state_q),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.state_nxt   (state_nxt),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// advance the expression state with each request leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || !out_stall) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = v_s2;
	assign number_found = res_s2.number_found;
	assign number_value = res_s2.number_value;
	assign text_done    = res_s2.text_done;

endmodule

>>> src/kane_step.sv
// Per-byte update of the extractor state and the result of one request.
`timescale 1ns / 1ps

module kane_step import kane_pkg::*; (
	input  kane_state_t  state_cur,
	input  logic [7:0]   text_byte,
	input  logic         end_of_text,
	output kane_state_t  state_nxt,
	output kane_result_t result
);

	localparam int VB = VALUE_BITS;

	typedef struct packed {
		logic [VB-1:0] sum;
		logic          ok;
	} sum_t;

	typedef struct packed {
		logic          found;
		logic [VB-1:0] value;
	} hit_t;

	function automatic hit_t flush_hit(kane_expr_t ex, sum_t s);
		hit_t h;
		h.found = ex.in_unit_expression ?
			(!ex.total_overflowed && s.ok && (s.sum != '0)) : ex.have_number;
		h.value = ex.in_unit_expression ? s.sum : ex.last_number;
		return h;
	endfunction

	function automatic hit_t keep_first(hit_t old_h, hit_t new_h);
		return old_h.found ? old_h : new_h;
	endfunction

	logic                 is_comma;
	logic                 is_digit;
	logic                 is_lead;
	logic                 is_mid;
	logic [VB-1:0]        run_base;
	logic [VB+3:0]        run_ext;
	logic                 run_ovf_now;
	logic [VB-1:0]        run_new;
	logic                 rovf_new;
	logic [VB-1:0]        add_a;
	logic [VB:0]          sum_a_ext;
	logic [VB-1:0]        run_sel;
	logic [VB:0]          sum_b_ext;
	sum_t                 sum_a;
	sum_t                 sum_b;
	logic [UNIT_BITS-1:0] unit_factor;
	logic [VB-1:0]        mult_in;
	logic [VB+UNIT_BITS-1:0] prod;
	logic [VB+UNIT_BITS:0]   total_ext;
	logic                 total_ovf;
	logic [VB-1:0]        ut_new;
	logic                 tovf_new;

	kane_expr_t           ex;
	sum_t                 es;
	logic [15:0]          pb;
	logic [1:0]           pc;
	logic                 in_run;
	logic [VB-1:0]        run;
	logic                 rovf;
	hit_t                 hit;

	assign is_comma = (text_byte == CHAR_COMMA);
	assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
	assign is_lead  = (text_byte == LEAD_EB) || (text_byte == LEAD_EC);
	assign is_mid   = ((state_cur.prefix_bytes[7:0] == LEAD_EB) &&
			((text_byte == MID_A7) || (text_byte == MID_B0))) ||
		((state_cur.prefix_bytes[7:0] == LEAD_EC) &&
			((text_byte == MID_B2) || (text_byte == MID_8B)));

	// digit run: value * 10 + digit, overflow when it leaves the value range
	assign run_base    = state_cur.in_digit_run ? state_cur.digit_run_value : '0;
	assign run_ext     = ({4'b0000, run_base} << 3) + ({4'b0000, run_base} << 1) +
		(VB+4)'(text_byte[3:0]);
	assign run_ovf_now = |run_ext[VB+3:VB];
	assign run_new     = run_ovf_now ? run_base : run_ext[VB-1:0];
	assign rovf_new    = (state_cur.in_digit_run && state_cur.run_overflowed) || run_ovf_now;

	// flush sum of the stored expression
	assign add_a     = state_cur.expr.have_number ? state_cur.expr.last_number : '0;
	assign sum_a_ext = {1'b0, state_cur.expr.unit_total} + {1'b0, add_a};
	assign sum_a     = {sum_a_ext[VB-1:0], !sum_a_ext[VB]};

	// flush sum once a finished digit run becomes the trailing number
	assign run_sel   = is_digit ? run_new : state_cur.digit_run_value;
	assign sum_b_ext = {1'b0, state_cur.expr.unit_total} + {1'b0, run_sel};
	assign sum_b     = {sum_b_ext[VB-1:0], !sum_b_ext[VB]};

	always_comb begin
		unit_factor = UNIT_NONE;
		if ((state_cur.prefix_bytes == {MID_A7, LEAD_EB}) && (text_byte == TAIL_8C)) begin
			unit_factor = UNIT_10000;
		end else if ((state_cur.prefix_bytes == {MID_B2, LEAD_EC}) &&
			(text_byte == TAIL_9C)) begin
			unit_factor = UNIT_1000;
		end else if ((state_cur.prefix_bytes == {MID_B0, LEAD_EB}) &&
			(text_byte == TAIL_B1)) begin
			unit_factor = UNIT_100;
		end else if ((state_cur.prefix_bytes == {MID_8B, LEAD_EC}) &&
			(text_byte == TAIL_AD)) begin
			unit_factor = UNIT_10;
		end
	end

	// unit apply: total += (number or 1) * unit
	assign mult_in   = state_cur.expr.have_number ? state_cur.expr.last_number : VB'(1);

	always_comb begin
		case (unit_factor)
			UNIT_10000: prod = (VB+UNIT_BITS)'(mult_in) * (VB+UNIT_BITS)'(UNIT_10000);
			UNIT_1000:  prod = (VB+UNIT_BITS)'(mult_in) * (VB+UNIT_BITS)'(UNIT_1000);
			UNIT_100:   prod = (VB+UNIT_BITS)'(mult_in) * (VB+UNIT_BITS)'(UNIT_100);
			UNIT_10:    prod = (VB+UNIT_BITS)'(mult_in) * (VB+UNIT_BITS)'(UNIT_10);
			default:    prod = '0;
		endcase
	end

	assign total_ext = (VB+UNIT_BITS+1)'(prod) +
		(VB+UNIT_BITS+1)'(state_cur.expr.unit_total);
	assign total_ovf = |total_ext[VB+UNIT_BITS:VB];
	assign tovf_new  = state_cur.expr.total_overflowed || total_ovf;
	assign ut_new    = tovf_new ? state_cur.expr.unit_total : total_ext[VB-1:0];

	always_comb begin
		ex     = state_cur.expr;
		es     = sum_a;
		pb     = state_cur.prefix_bytes;
		pc     = state_cur.prefix_count;
		in_run = state_cur.in_digit_run;
		run    = state_cur.digit_run_value;
		rovf   = state_cur.run_overflowed;
		hit    = '0;

		if (!is_comma) begin
			if (is_digit) begin
				if (pc != PC_EMPTY) begin
					hit = keep_first(hit, flush_hit(ex, es));
					ex  = '0;
					pb  = '0;
					pc  = PC_EMPTY;
				end
				in_run = 1'b1;
				run    = run_new;
				rovf   = rovf_new;
			end else begin
				if (in_run) begin
					if (rovf) begin
						hit = keep_first(hit, flush_hit(ex, es));
						ex  = '0;
					end else begin
						ex.last_number = run;
						ex.have_number = 1'b1;
						es             = sum_b;
					end
					in_run = 1'b0;
					run    = '0;
					rovf   = 1'b0;
				end
				case (pc)
					PC_EMPTY: begin
						if (is_lead) begin
							pb = {8'h00, text_byte};
							pc = PC_ONE;
						end else begin
							hit = keep_first(hit, flush_hit(ex, es));
							ex  = '0;
						end
					end
					PC_ONE: begin
						if (is_mid) begin
							pb[15:8] = text_byte;
							pc       = PC_TWO;
						end else begin
							hit = keep_first(hit, flush_hit(ex, es));
							ex  = '0;
							pb  = is_lead ? {8'h00, text_byte} : 16'h0000;
							pc  = is_lead ? PC_ONE : PC_EMPTY;
						end
					end
					default: begin
						if (unit_factor != UNIT_NONE) begin
							ex.unit_total         = ut_new;
							ex.total_overflowed   = tovf_new;
							ex.last_number        = '0;
							ex.have_number        = 1'b0;
							ex.in_unit_expression = 1'b1;
							es.sum                = ut_new;
							es.ok                 = 1'b1;
							pb                    = '0;
							pc                    = PC_EMPTY;
						end else begin
							hit = keep_first(hit, flush_hit(ex, es));
							ex  = '0;
							pb  = is_lead ? {8'h00, text_byte} : 16'h0000;
							pc  = is_lead ? PC_ONE : PC_EMPTY;
						end
					end
				endcase
			end
		end

		if (end_of_text) begin
			if (in_run) begin
				if (rovf) begin
					hit = keep_first(hit, flush_hit(ex, es));
					ex  = '0;
				end else begin
					ex.last_number = run;
					ex.have_number = 1'b1;
					es             = sum_b;
				end
			end
			if (pc != PC_EMPTY) begin
				hit = keep_first(hit, flush_hit(ex, es));
				ex  = '0;
			end
			hit    = keep_first(hit, flush_hit(ex, es));
			ex     = '0;
			pb     = '0;
			pc     = PC_EMPTY;
			in_run = 1'b0;
			run    = '0;
			rovf   = 1'b0;
		end

		state_nxt.expr            = ex;
		state_nxt.digit_run_value = run;
		state_nxt.in_digit_run    = in_run;
		state_nxt.run_overflowed  = rovf;
		state_nxt.prefix_bytes    = pb;
		state_nxt.prefix_count    = pc;

		result.number_found = hit.found;
		result.number_value = hit.found ? hit.value : '0;
		result.text_done    = end_of_text;
	end

endmodule

>>> src/kane_checker.sv
// Port-level checker for the amount number extractor, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kane_checker import kane_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [7:0]            text_byte,
	input logic                  end_of_text,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  number_found,
	input logic [VALUE_BITS-1:0] number_value,
	input logic                  text_done
);

	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(number_value) && $stable(number_found) && $stable(text_done))
	`ASSERT_IMP(a_quiet_zero, clk, arst_n, out_valid && !number_found, number_value == '0)
	`ASSERT_NXT(a_flow, clk, arst_n, (in_valid && !in_stall) ##1 !out_stall, out_valid)
	`ASSERT_NXT(a_done_echo, clk, arst_n, (in_valid && !in_stall && end_of_text) ##1 !out_stall, out_valid && text_done)
	`ASSERT_NXT(a_comma_quiet, clk, arst_n, (in_valid && !in_stall && (text_byte == CHAR_COMMA) && !end_of_text) ##1 !out_stall, !number_found)

endmodule

bind korean_amount_number_extractor kane_checker u_kane_checker (.*);

>>> dv/tb_top.sv
// Self-checking bench for the amount number extractor: random byte texts, shadow parser, in-order compare.
`timescale 1ns / 1ps

module tb_top;
	import kane_pkg::*;

	localparam int ITEM_TARGET  = 1300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_START   = 450;
	localparam int HOLD_CYCLES  = 80;
	localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_req_t;

	typedef enum logic [1:0] {LEAD_HELD, LEAD_APPLIED, LEAD_FAILED} lead_status_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [7:0]            text_byte    = 8'h00;
	logic                  end_of_text  = 1'b0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic                  number_found;
	logic [VALUE_BITS-1:0] number_value;
	logic                  text_done;

	text_req_t    pending_req[$];
	logic [7:0]   text_buf[$];
	kane_result_t expected_hits[$];

	int unsigned sent_cnt    = 0;
	int unsigned text_cnt    = 0;
	int unsigned found_cnt   = 0;
	int unsigned err_cnt     = 0;
	int unsigned cycle_cnt   = 0;
	int unsigned hold_left   = 0;
	logic        hold_done   = 1'b0;
	wire [1:0]   phase       = 2'((sent_cnt / 100) % 4);

	// shadow parser state
	logic [62:0] unit_sum   = '0;
	logic [62:0] held_num   = '0;
	logic        held_valid = 1'b0;
	logic        in_expr    = 1'b0;
	logic        sum_ovf    = 1'b0;
	logic [62:0] run_val    = '0;
	logic        in_run     = 1'b0;
	logic        run_ovf    = 1'b0;
	logic [15:0] lead_bytes = '0;
	logic [1:0]  lead_cnt   = PC_EMPTY;
	logic        emit_hit;
	logic [62:0] emit_val;

	korean_amount_number_extractor i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.number_found(number_found),
		.number_value(number_value),
		.text_done   (text_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int send_idle_pct(input logic [1:0] ph);
		case (ph)
			2'd1:    return 75;
			2'd3:    return 13;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input logic [1:0] ph);
		case (ph)
			2'd2:    return 75;
			2'd3:    return 13;
			default: return 0;
		endcase
	endfunction

	function automatic void close_amount();
		logic        found;
		logic [63:0] v;
		logic [63:0] add;
		found = 1'b0;
		v = '0;
		if (in_expr) begin
			if (!sum_ovf) begin
				add = held_valid ? {1'b0, held_num} : 64'd0;
				if (add <= VALUE_MAX - {1'b0, unit_sum}) begin
					v = {1'b0, unit_sum} + add;
					found = (v != 0);
				end
			end
		end else if (held_valid) begin
			v = {1'b0, held_num};
			found = 1'b1;
		end
		unit_sum = '0;
		held_num = '0;
		held_valid = 1'b0;
		in_expr = 1'b0;
		sum_ovf = 1'b0;
		if (found && !emit_hit) begin
			emit_hit = 1'b1;
			emit_val = v[62:0];
		end
	endfunction

	function automatic void close_digits();
		if (in_run) begin
			in_run = 1'b0;
			if (run_ovf) begin
				close_amount();
			end else begin
				held_num = run_val;
				held_valid = 1'b1;
			end
			run_val = '0;
			run_ovf = 1'b0;
		end
	endfunction

	function automatic void apply_scale(input logic [63:0] scale);
		logic [63:0] m;
		logic [63:0] prod;
		m = held_valid ? {1'b0, held_num} : 64'd1;
		if (!sum_ovf) begin
			prod = m * scale;
			if (m > VALUE_MAX / scale || prod > VALUE_MAX - {1'b0, unit_sum})
				sum_ovf = 1'b1;
			else
				unit_sum = unit_sum + prod[62:0];
		end
		held_valid = 1'b0;
		held_num = '0;
		in_expr = 1'b1;
	endfunction

	function automatic lead_status_t take_lead(input logic [7:0] c);
		logic [7:0]  p0;
		logic [7:0]  p1;
		logic [63:0] scale;
		p0 = lead_bytes[7:0];
		p1 = lead_bytes[15:8];
		scale = '0;
		if (lead_cnt == PC_EMPTY) begin
			if (c == LEAD_EB || c == LEAD_EC) begin
				lead_bytes = {8'h00, c};
				lead_cnt = PC_ONE;
				return LEAD_HELD;
			end
			return LEAD_FAILED;
		end
		if (lead_cnt == PC_ONE) begin
			if ((p0 == LEAD_EB && (c == MID_A7 || c == MID_B0)) ||
				(p0 == LEAD_EC && (c == MID_B2 || c == MID_8B))) begin
				lead_bytes = {c, p0};
				lead_cnt = PC_TWO;
				return LEAD_HELD;
			end
			return LEAD_FAILED;
		end
		if (p0 == LEAD_EB && p1 == MID_A7 && c == TAIL_8C)
			scale = 64'(UNIT_10000);
		else if (p0 == LEAD_EC && p1 == MID_B2 && c == TAIL_9C)
			scale = 64'(UNIT_1000);
		else if (p0 == LEAD_EB && p1 == MID_B0 && c == TAIL_B1)
			scale = 64'(UNIT_100);
		else if (p0 == LEAD_EC && p1 == MID_8B && c == TAIL_AD)
			scale = 64'(UNIT_10);
		if (scale == 0)
			return LEAD_FAILED;
		apply_scale(scale);
		lead_bytes = '0;
		lead_cnt = PC_EMPTY;
		return LEAD_APPLIED;
	endfunction

	function automatic void drop_lead();
		if (lead_cnt != PC_EMPTY) begin
			close_amount();
			lead_bytes = '0;
			lead_cnt = PC_EMPTY;
		end
	endfunction

	function automatic kane_result_t predict_number(input logic [7:0] c, input logic eot);
		kane_result_t r;
		logic [63:0]  d;
		emit_hit = 1'b0;
		emit_val = '0;
		if (c != CHAR_COMMA) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				d = 64'(c - CHAR_ZERO);
				drop_lead();
				if (!in_run) begin
					in_run = 1'b1;
					run_val = '0;
					run_ovf = 1'b0;
				end
				if ({1'b0, run_val} > (VALUE_MAX - d) / 10)
					run_ovf = 1'b1;
				else
					run_val = run_val * 63'd10 + d[62:0];
			end else begin
				close_digits();
				if (take_lead(c) == LEAD_FAILED) begin
					if (lead_cnt != PC_EMPTY) begin
						drop_lead();
						if (take_lead(c) == LEAD_FAILED)
							close_amount();
					end else begin
						close_amount();
					end
				end
			end
		end
		if (eot) begin
			close_digits();
			drop_lead();
			close_amount();
		end
		r.number_found = emit_hit;
		r.number_value = emit_hit ? emit_val : '0;
		r.text_done = eot;
		return r;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		text_buf.insert(text_buf.size(), b);
	endtask

	task automatic push_unit(input int k);
		case (k)
			0: begin push_byte(LEAD_EB); push_byte(MID_A7); push_byte(TAIL_8C); end
			1: begin push_byte(LEAD_EC); push_byte(MID_B2); push_byte(TAIL_9C); end
			2: begin push_byte(LEAD_EB); push_byte(MID_B0); push_byte(TAIL_B1); end
			default: begin push_byte(LEAD_EC); push_byte(MID_8B); push_byte(TAIL_AD); end
		endcase
	endtask

	task automatic push_digits(input int len);
		for (int i = 0; i < len; i++)
			push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic close_text();
		text_req_t t;
		while (text_buf.size() != 0) begin
			t.ch = text_buf.pop_front();
			t.last = (text_buf.size() == 0);
			pending_req.insert(pending_req.size(), t);
		end
		text_cnt++;
	endtask

	task automatic build_random_text();
		int ntok;
		int pick;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
		end else begin
			ntok = $urandom_range(1, 12);
			for (int i = 0; i < ntok; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					if ($urandom_range(0, 9) == 0)
						push_digits($urandom_range(17, 21));
					else
						push_digits($urandom_range(1, 4));
				end else if (pick < 45) begin
					push_byte(CHAR_COMMA);
				end else if (pick < 70) begin
					push_unit($urandom_range(0, 3));
				end else if (pick < 80) begin
					push_byte(8'($urandom_range(0, 255)));
				end else if (pick < 90) begin
					push_byte($urandom_range(0, 1) ? LEAD_EB : LEAD_EC);
					if ($urandom_range(0, 1))
						push_byte($urandom_range(0, 1) ? MID_A7 : MID_B2);
					push_byte(8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(128, 255)));
				end
			end
		end
		close_text();
	endtask

	// driver: hold payload while stalled, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_valid)
					expected_hits.insert(expected_hits.size(),
						predict_number(text_byte, end_of_text));
				if (pending_req.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct(phase)) begin
					text_req_t t;
					t = pending_req.pop_front();
					in_valid <= 1'b1;
					text_byte <= t.ch;
					end_of_text <= t.last;
					sent_cnt <= sent_cnt + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && sent_cnt >= HOLD_START) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				kane_result_t want;
				if (expected_hits.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: found=%0b value=%0d done=%0b",
							number_found, number_value, text_done);
				end else begin
					want = expected_hits.pop_front();
					if (want.number_found)
						found_cnt++;
					if (number_found !== want.number_found ||
						number_value !== want.number_value ||
						text_done !== want.text_done) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display({"result mismatch: exp found=%0b value=%0d done=%0b, ",
								"got found=%0b value=%0d done=%0b"},
								want.number_found, want.number_value, want.text_done,
								number_found, number_value, text_done);
					end
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct(phase));
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		// directed: all four units, digits, comma on the final byte
		push_byte(CHAR_ZERO + 8'd3);
		push_unit(0);
		push_byte(CHAR_ZERO + 8'd2);
		push_unit(1);
		push_unit(2);
		push_byte(CHAR_ZERO + 8'd7);
		push_unit(3);
		push_byte(CHAR_COMMA);
		close_text();
		// directed: failed prefixes at both depths, byte extremes
		push_byte(LEAD_EB);
		push_byte(8'h41);
		push_byte(LEAD_EB);
		push_byte(MID_A7);
		push_byte(8'h00);
		push_byte(8'hFF);
		close_text();
		push_byte(CHAR_COMMA);
		close_text();
		while (pending_req.size() < ITEM_TARGET)
			build_random_text();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_req.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d texts, %0d numbers extracted", sent_cnt, text_cnt,
			found_cnt);
		$display("idle phases: none, sender 75%%, receiver 75%%, both 13%%, plus one %0d-cycle hold",
			HOLD_CYCLES);
		if (err_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatching results", err_cnt);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
